// ===== rtl/fhkv_pkg.sv =====
package fhkv_pkg;

  // table geometry, BUCKETS must be a power of two (bucket index is the low hash bits)
  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int FILL_W   = $clog2(WAYS + 1);
  localparam int ENTRIES  = BUCKETS * WAYS;
  localparam int ADDR_W   = $clog2(ENTRIES);

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] HASH_MULT = 32'h01000193;
  localparam int          KEY_BYTES = KEY_W / 8;
  localparam int          STEP_W    = $clog2(KEY_BYTES);

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_EXISTS = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

endpackage

// ===== rtl/fhkv_if.sv =====
interface fhkv_req_if
  import fhkv_pkg::*;
();
  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [KEY_W-1:0]   lookup_key;
  logic [VALUE_W-1:0] new_value;

  modport source (output valid, output command, output lookup_key, output new_value,
                  input ready);
  modport sink   (input valid, input command, input lookup_key, input new_value,
                  output ready);
endinterface

interface fhkv_rsp_if
  import fhkv_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic               found;
  logic               bucket_full;

  modport source (output valid, output read_value, output found, output bucket_full,
                  input ready);
  modport sink   (input valid, input read_value, input found, input bucket_full,
                  output ready);
endinterface

// ===== rtl/fnv1a_hashed_key_value_table.sv =====
// channel | dir | payload                              | handshake
// req     | in  | command, lookup_key, new_value       | valid / ready
// rsp     | out | read_value, found, bucket_full       | valid / ready
//
// a request hashes the key one byte at a time on the shared fnv multiplier, then reads the
// bucket fill, then reads and compares the key/value of each way below the fill, stopping
// at the way that matches, then resolves, then returns to idle to take the next request.
// rst clears control state and the per-bucket valid bits; key and value memories are
// not cleared. a stalled rsp holds the finished result; the next request is taken
// while it waits.
module fnv1a_hashed_key_value_table
  import fhkv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fhkv_req_if.sink   req,
  fhkv_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FILL_RD,
    ST_SCAN,
    ST_CMP,
    ST_RESOLVE
  } state_t;

  state_t             state;
  logic [STEP_W-1:0]  step;
  cmd_t               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic [31:0]        h;
  logic [FILL_W-1:0]  fill_rd;
  logic               fvalid_q;
  logic [FILL_W-1:0]  way;
  logic               hit;
  logic [KEY_W-1:0]   key_rd;
  logic [VALUE_W-1:0] val_rd;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               out_found;
  logic               out_full;

  logic [KEY_W-1:0]   key_mem  [ENTRIES];
  logic [VALUE_W-1:0] val_mem  [ENTRIES];
  logic [FILL_W-1:0]  fill_mem [BUCKETS];
  logic [BUCKETS-1:0] fill_valid;

  logic [7:0]          key_byte;
  logic [31:0]         mix;
  logic [BUCKET_W-1:0] bucket;
  logic [FILL_W-1:0]   fill;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                advance;
  logic                set_hit;
  logic                set_new;
  logic                bucket_is_full;
  logic                key_we;
  logic                val_we;

  assign key_byte = key_q[step*8 +: 8];
  assign mix      = h ^ {24'd0, key_byte};
  assign bucket   = h[BUCKET_W-1:0];
  assign fill     = fvalid_q ? fill_rd : '0;
  assign base     = ADDR_W'(bucket) * ADDR_W'(WAYS);
  assign rd_addr  = base + ADDR_W'(way);
  assign bucket_is_full = (fill >= FILL_W'(WAYS));
  assign set_hit  = (cmd_q == CMD_SET) && hit;
  assign set_new  = (cmd_q == CMD_SET) && !hit && !bucket_is_full;
  // on a hit way still points at the matching entry
  assign wr_addr  = set_hit ? rd_addr : base + ADDR_W'(fill);
  assign advance  = !out_valid || rsp.ready;
  assign key_we   = (state == ST_RESOLVE) && advance && set_new;
  assign val_we   = (state == ST_RESOLVE) && advance && (set_new || set_hit);

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_value;
  assign rsp.found       = out_found;
  assign rsp.bucket_full = out_full;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_q;
    end
    if (state == ST_SCAN) begin
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      fill_mem[bucket] <= fill + FILL_W'(1);
    end
    if (state == ST_FILL_RD) begin
      fill_rd <= fill_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_valid <= '0;
      fvalid_q   <= 1'b0;
    end else begin
      if (key_we) begin
        fill_valid[bucket] <= 1'b1;
      end
      if (state == ST_FILL_RD) begin
        fvalid_q <= fill_valid[bucket];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      way       <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_RESOLVE) && advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.command;
            key_q <= req.lookup_key;
            val_q <= req.new_value;
            h     <= FNV_BASIS;
            step  <= '0;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          // one key byte per cycle through the shared multiplier
          h    <= mix * HASH_MULT;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(KEY_BYTES - 1)) begin
            state <= ST_FILL_RD;
          end
        end
        ST_FILL_RD: begin
          way   <= '0;
          hit   <= 1'b0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (way < fill) begin
            state <= ST_CMP;
          end else begin
            state <= ST_RESOLVE;
          end
        end
        ST_CMP: begin
          if (key_rd == key_q) begin
            hit   <= 1'b1;
            state <= ST_RESOLVE;
          end else begin
            way   <= way + FILL_W'(1);
            state <= ST_SCAN;
          end
        end
        ST_RESOLVE: begin
          if (advance) begin
            out_value <= ((cmd_q == CMD_GET) && hit) ? val_rd : '0;
            out_found <= hit && (cmd_q != CMD_UNUSED);
            out_full  <= (cmd_q == CMD_SET) && !hit && bucket_is_full;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
